// ----- hdl/tdi_pkg.sv -----
package tdi_pkg;
  localparam int MAX_UNIQUE_DEF = 256;
  localparam int MAX_TILE_PIXELS_DEF = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam logic [4:0] PPT_RESET = 5'd9;
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;
  localparam logic [0:0] REG_PPT = 1'b0;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_SCAN,
    ST_DONE
  } state_t;
endpackage

// ----- hdl/tdi_cell.sv -----
module tdi_cell (
  input  logic        clk,
  input  logic        shift_en,
  input  logic [23:0] pix_in,
  output logic [23:0] pix_out
);
  logic [23:0] pix_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      pix_r <= pix_in;
    end
  end

  assign pix_out = pix_r;
endmodule

// ----- hdl/tile_dedup_indexer.sv -----
// Tile dedup indexer. Pixels of one tile enter one per cycle through a chain of pixel cells
// while busy is low. When the last pixel of a tile is taken, busy rises and the block walks
// the stored unique tiles one pixel a cycle out of the tile memory, stopping at the first
// match. One result follows as a single-cycle out_valid strobe; the receiver cannot stall
// it and must take it in that cycle. A clear item or a write of pixels_per_tile empties the
// table and drops any partial tile.
module tile_dedup_indexer #(
  parameter int MAX_UNIQUE      = tdi_pkg::MAX_UNIQUE_DEF,
  parameter int MAX_TILE_PIXELS = tdi_pkg::MAX_TILE_PIXELS_DEF,
  parameter int COUNT_BITS      = tdi_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  output logic [7:0]  out_tile_id,
  output logic        out_is_new,
  output logic [15:0] out_occurrences,
  output logic [8:0]  out_unique_total,
  output logic        out_table_full,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int PW = (MAX_TILE_PIXELS > 1) ? $clog2(MAX_TILE_PIXELS) : 1;
  localparam int NW = $clog2(MAX_TILE_PIXELS + 1);
  localparam int IW = (MAX_UNIQUE > 1) ? $clog2(MAX_UNIQUE) : 1;
  localparam int UW = $clog2(MAX_UNIQUE + 1);
  localparam int AW = IW + PW;
  localparam int DEPTH = MAX_UNIQUE * (2 ** PW);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  tdi_pkg::state_t state_r, state_nxt;
  logic [4:0]    ppt_r;
  logic [NW-1:0] n_len;
  logic [NW-1:0] pos_r, pos_nxt;
  logic [UW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] id_r, id_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic          rd_v_r, rd_v_nxt;
  logic          rd_last_r;
  logic [IW-1:0] rd_id_r;
  logic          eq_r, eq_nxt;
  logic          found_r, found_nxt;
  logic [IW-1:0] fid_r, fid_nxt;
  logic          wr_r, wr_nxt;
  logic [23:0]   mem_q_r;
  logic [23:0]   mem [DEPTH];
  logic [COUNT_BITS-1:0] occ_mem [MAX_UNIQUE];
  logic [COUNT_BITS-1:0] occ_q_r;
  logic          fin_r;
  logic          cfg_wr, accept, is_pix, is_clr, tile_done, scan_end;
  logic [23:0]   chain [MAX_TILE_PIXELS+1];
  logic          shift_en;
  logic [23:0]   cmp_pix;
  logic [AW-1:0] rd_addr, wr_addr;

  assign pready = 1'b1;
  assign prdata = {27'd0, ppt_r};
  assign cfg_wr = psel & penable & pwrite & (paddr == tdi_pkg::REG_PPT);
  assign busy   = (state_r != tdi_pkg::ST_FILL);
  assign accept = start & ~busy;
  assign is_clr = accept & (in_kind == tdi_pkg::KIND_CLEAR);
  assign is_pix = accept & (in_kind == tdi_pkg::KIND_PIXEL);

  always_comb begin
    if (ppt_r == 5'd0) begin
      n_len = NW'(1);
    end else if (32'(ppt_r) > MAX_TILE_PIXELS) begin
      n_len = NW'(MAX_TILE_PIXELS);
    end else begin
      n_len = NW'(ppt_r);
    end
  end

  assign tile_done = is_pix & ((pos_r >= n_len) ? (n_len == NW'(1)) : (pos_r + NW'(1) >= n_len));

  // the chain rotates: new pixels enter at cell 0, rotation during scan keeps the order
  assign shift_en = is_pix | ((state_r == tdi_pkg::ST_SCAN) & rd_v_r) | wr_r;
  assign chain[0] = (state_r == tdi_pkg::ST_FILL) ? {in_red, in_green, in_blue} : chain[n_len];

  genvar g;
  generate
    for (g = 0; g < MAX_TILE_PIXELS; g++) begin : g_cell
      tdi_cell u_cell (
        .clk(clk), .shift_en(shift_en), .pix_in(chain[g]), .pix_out(chain[g+1])
      );
    end
  endgenerate

  assign cmp_pix = chain[n_len];

  assign scan_end = (state_r == tdi_pkg::ST_SCAN) && !rd_v_r && !rd_v_nxt;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    id_nxt    = id_r;
    rp_nxt    = rp_r;
    rd_v_nxt  = 1'b0;
    eq_nxt    = eq_r;
    found_nxt = found_r;
    fid_nxt   = fid_r;
    wr_nxt    = wr_r;
    case (state_r)
      tdi_pkg::ST_FILL: begin
        if (is_pix) begin
          pos_nxt = (pos_r >= n_len) ? NW'(1) : pos_r + NW'(1);
          if (tile_done) begin
            pos_nxt   = '0;
            state_nxt = tdi_pkg::ST_SCAN;
            id_nxt    = '0;
            rp_nxt    = '0;
            eq_nxt    = 1'b1;
            found_nxt = 1'b0;
            rd_v_nxt  = (cnt_r != '0);
          end
        end
      end
      tdi_pkg::ST_SCAN: begin
        if (rd_v_r) begin
          eq_nxt = eq_r & (mem_q_r == cmp_pix);
          if (rd_last_r) begin
            if (eq_r && (mem_q_r == cmp_pix) && !found_r) begin
              found_nxt = 1'b1;
              fid_nxt   = rd_id_r;
            end
            eq_nxt = 1'b1;
          end
        end
        if (rd_v_r && !found_nxt) begin
          if (32'(rp_r) + 1 < 32'(n_len)) begin
            rp_nxt   = rp_r + PW'(1);
            rd_v_nxt = 1'b1;
          end else if (32'(id_r) + 1 < 32'(cnt_r)) begin
            rp_nxt   = '0;
            id_nxt   = id_r + IW'(1);
            rd_v_nxt = 1'b1;
          end
        end
        if (!rd_v_r || found_nxt) begin
          if (!found_nxt && (32'(cnt_r) < MAX_UNIQUE)) begin
            wr_nxt = 1'b1;
            rp_nxt = '0;
          end
          state_nxt = tdi_pkg::ST_DONE;
        end
      end
      tdi_pkg::ST_DONE: begin
        if (wr_r) begin
          rp_nxt = rp_r + PW'(1);
          if (32'(rp_r) + 1 >= 32'(n_len)) begin
            wr_nxt = 1'b0;
          end
        end else if (!fin_r) begin
          state_nxt = tdi_pkg::ST_FILL;
        end
      end
      default: state_nxt = tdi_pkg::ST_FILL;
    endcase
    if (is_clr || cfg_wr) begin
      pos_nxt = '0;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (is_clr || cfg_wr) begin
      cnt_nxt = '0;
    end else if (wr_r && (32'(rp_r) + 1 >= 32'(n_len))) begin
      cnt_nxt = cnt_r + UW'(1);
    end
  end

  assign rd_addr = {id_nxt, rp_nxt};
  assign wr_addr = {IW'(cnt_r), rp_r};

  always_ff @(posedge clk) begin
    if (rd_v_nxt) begin
      mem_q_r <= mem[rd_addr];
    end
    if (wr_r) begin
      mem[wr_addr] <= cmp_pix;
    end
    rd_last_r <= 32'(rp_nxt) + 1 >= 32'(n_len);
    rd_id_r   <= id_nxt;
    occ_q_r   <= occ_mem[fid_nxt];
  end

  // result: found -> bump count, new -> count one, else full
  logic fire;
  logic [COUNT_BITS-1:0] occ_new;
  assign fire    = (state_r == tdi_pkg::ST_DONE) && fin_r;
  assign occ_new = (occ_q_r == CMAX) ? occ_q_r : occ_q_r + COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (fire && found_r) begin
      occ_mem[fid_r] <= occ_new;
    end else if (wr_r && (32'(rp_r) + 1 >= 32'(n_len))) begin
      occ_mem[IW'(cnt_r)] <= COUNT_BITS'(1);
    end
  end

  logic new_r, full_r;
  logic [IW-1:0] nid_r;
  always_ff @(posedge clk) begin
    if (scan_end || (state_r == tdi_pkg::ST_SCAN && state_nxt == tdi_pkg::ST_DONE)) begin
      new_r  <= !found_nxt;
      full_r <= !found_nxt && !(32'(cnt_r) < MAX_UNIQUE);
      nid_r  <= IW'(cnt_r);
    end
  end

  logic [UW-1:0] tot_c;
  assign tot_c = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fire && !wr_r;
    end
    out_tile_id      <= full_r ? 8'd0 : (found_r ? 8'(fid_r) : 8'(nid_r));
    out_is_new       <= new_r;
    out_occurrences  <= full_r ? 16'd0 : (found_r ? 16'(occ_new) : 16'd1);
    out_unique_total <= 9'(tot_c);
    out_table_full   <= full_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdi_pkg::ST_FILL;
      ppt_r   <= tdi_pkg::PPT_RESET;
      pos_r   <= '0;
      cnt_r   <= '0;
      wr_r    <= 1'b0;
      fin_r   <= 1'b0;
      rd_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        ppt_r <= pwdata[4:0];
      end
      pos_r  <= pos_nxt;
      cnt_r  <= cnt_nxt;
      wr_r   <= wr_nxt;
      rd_v_r <= rd_v_nxt;
      if (state_r == tdi_pkg::ST_SCAN && state_nxt == tdi_pkg::ST_DONE) begin
        fin_r <= 1'b1;
      end else if (fire && !wr_r) begin
        fin_r <= 1'b0;
      end
    end
    id_r    <= id_nxt;
    rp_r    <= rp_nxt;
    eq_r    <= eq_nxt;
    found_r <= found_nxt;
    fid_r   <= fid_nxt;
  end
endmodule

// ----- verif/tile_dedup_indexer_tb.sv -----
module tile_dedup_indexer_tb;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int TPL_COUNT = 8;

  typedef struct packed {
    logic [7:0]  tile_id;
    logic        is_new;
    logic [15:0] occurrences;
    logic [8:0]  unique_total;
    logic        table_full;
  } tile_result_t;

  typedef struct packed {
    logic         kind;
    logic [7:0]   red;
    logic [7:0]   green;
    logic [7:0]   blue;
    logic         typed;
    tile_result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_kind;
  logic [7:0]  in_red;
  logic [7:0]  in_green;
  logic [7:0]  in_blue;
  logic        out_valid;
  logic [7:0]  out_tile_id;
  logic        out_is_new;
  logic [15:0] out_occurrences;
  logic [8:0]  out_unique_total;
  logic        out_table_full;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [0:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tile_dedup_indexer dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_tile_id(out_tile_id), .out_is_new(out_is_new),
    .out_occurrences(out_occurrences), .out_unique_total(out_unique_total),
    .out_table_full(out_table_full),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // tile store mirror
  logic [23:0]  tile_mem [tdi_pkg::MAX_UNIQUE_DEF][tdi_pkg::MAX_TILE_PIXELS_DEF];
  int unsigned  seen_cnt [tdi_pkg::MAX_UNIQUE_DEF];
  int unsigned  uniq_cnt;
  logic [23:0]  tile_buf [tdi_pkg::MAX_TILE_PIXELS_DEF];
  int unsigned  pix_pos;
  logic [4:0]   tile_size_reg;

  tile_result_t expected_results[$];
  int           errors;
  int           idle_cycles;
  int           burst_left;
  logic [23:0]  templates [TPL_COUNT][tdi_pkg::MAX_TILE_PIXELS_DEF];

  // all-black, all-white and cleared-table rows are known up front
  stim_row_t dir_tab[14] = '{
    '{tdi_pkg::KIND_PIXEL, 8'h00, 8'h00, 8'h00, 1'b1, '{8'd0, 1'b1, 16'd1, 9'd1, 1'b0}},
    '{tdi_pkg::KIND_PIXEL, 8'hff, 8'hff, 8'hff, 1'b1, '{8'd1, 1'b1, 16'd1, 9'd2, 1'b0}},
    '{tdi_pkg::KIND_PIXEL, 8'h00, 8'h00, 8'h00, 1'b1, '{8'd0, 1'b0, 16'd2, 9'd2, 1'b0}},
    '{tdi_pkg::KIND_CLEAR, 8'hff, 8'h00, 8'hff, 1'b0, '0},
    '{tdi_pkg::KIND_PIXEL, 8'hff, 8'hff, 8'hff, 1'b1, '{8'd0, 1'b1, 16'd1, 9'd1, 1'b0}},
    '{tdi_pkg::KIND_PIXEL, 8'ha5, 8'h5a, 8'hc3, 1'b0, '0},
    '{tdi_pkg::KIND_PIXEL, 8'h5a, 8'ha5, 8'h3c, 1'b0, '0},
    '{tdi_pkg::KIND_PIXEL, 8'hff, 8'hff, 8'hff, 1'b1, '{8'd0, 1'b0, 16'd2, 9'd3, 1'b0}},
    '{tdi_pkg::KIND_CLEAR, 8'h00, 8'hff, 8'h00, 1'b0, '0},
    '{tdi_pkg::KIND_CLEAR, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{tdi_pkg::KIND_PIXEL, 8'h80, 8'h00, 8'h00, 1'b1, '{8'd0, 1'b1, 16'd1, 9'd1, 1'b0}},
    '{tdi_pkg::KIND_PIXEL, 8'h00, 8'h80, 8'h00, 1'b0, '0},
    '{tdi_pkg::KIND_PIXEL, 8'h00, 8'h00, 8'h80, 1'b0, '0},
    '{tdi_pkg::KIND_PIXEL, 8'h80, 8'h00, 8'h00, 1'b0, '0}
  };

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic predict_item(input logic k, input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, output bit produced,
                              output tile_result_t res);
    int unsigned n;
    int hit;
    bit same;
    produced = 1'b0;
    res = '0;
    if (k == tdi_pkg::KIND_CLEAR) begin
      uniq_cnt = 0;
      pix_pos = 0;
      return;
    end
    n = (tile_size_reg == 0) ? 1 :
        (tile_size_reg > tdi_pkg::MAX_TILE_PIXELS_DEF) ? tdi_pkg::MAX_TILE_PIXELS_DEF :
        tile_size_reg;
    if (pix_pos >= n) pix_pos = 0;
    tile_buf[pix_pos] = {r, g, b};
    pix_pos++;
    if (pix_pos < n) return;
    pix_pos = 0;
    produced = 1'b1;
    hit = -1;
    for (int id = 0; id < uniq_cnt && hit < 0; id++) begin
      same = 1'b1;
      for (int p = 0; p < n; p++)
        if (tile_mem[id][p] != tile_buf[p]) same = 1'b0;
      if (same) hit = id;
    end
    if (hit >= 0) begin
      if (seen_cnt[hit] < 32'hffff) seen_cnt[hit]++;
      res.tile_id = hit[7:0];
      res.occurrences = seen_cnt[hit][15:0];
    end else if (uniq_cnt < tdi_pkg::MAX_UNIQUE_DEF) begin
      for (int p = 0; p < n; p++) tile_mem[uniq_cnt][p] = tile_buf[p];
      seen_cnt[uniq_cnt] = 1;
      res.tile_id = uniq_cnt[7:0];
      res.is_new = 1'b1;
      res.occurrences = 16'd1;
      uniq_cnt++;
    end else begin
      res.is_new = 1'b1;
      res.table_full = 1'b1;
    end
    res.unique_total = uniq_cnt[8:0];
  endtask

  task automatic send_item(input logic k, input logic [23:0] px, input bit typed,
                           input tile_result_t typed_res);
    bit produced;
    tile_result_t res;
    start <= 1'b1;
    in_kind <= k;
    {in_red, in_green, in_blue} <= px;
    do @(posedge clk); while (busy);
    predict_item(k, px[23:16], px[15:8], px[7:0], produced, res);
    if (produced) expected_results.push_back(typed ? typed_res : res);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 30);
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_tile_size(input logic [31:0] value);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    while (busy) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= tdi_pkg::REG_PPT;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tile_size_reg = value[4:0];
    uniq_cnt = 0;
    pix_pos = 0;
    @(posedge clk);
    if (prdata != {27'd0, value[4:0]}) begin
      errors++;
      $display("%0t: prdata exp %0d got %0d", $time, value[4:0], prdata);
    end
  endtask

  // mostly repeats of a few template tiles, with stray pixels and clears
  task automatic run_tiles(input int items);
    int tpl;
    tpl = 0;
    for (int t = 0; t < TPL_COUNT; t++)
      for (int p = 0; p < tdi_pkg::MAX_TILE_PIXELS_DEF; p++)
        templates[t][p] = ($urandom_range(0, 5) == 0) ? {24{t[0]}} : 24'($urandom);
    for (int i = 0; i < items; i++) begin
      if (pix_pos == 0) tpl = $urandom_range(0, TPL_COUNT - 1);
      if ($urandom_range(0, 49) == 0)
        send_item(tdi_pkg::KIND_CLEAR, 24'($urandom), 1'b0, '0);
      else if ($urandom_range(0, 12) == 0)
        send_item(tdi_pkg::KIND_PIXEL, 24'($urandom), 1'b0, '0);
      else
        send_item(tdi_pkg::KIND_PIXEL, templates[tpl][pix_pos], 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    tile_result_t got;
    tile_result_t want;
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      if (out_valid) begin
        got = '{out_tile_id, out_is_new, out_occurrences, out_unique_total, out_table_full};
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %p", $time, got);
        end else begin
          want = expected_results.pop_front();
          if (got.tile_id != want.tile_id)
            $display("%0t: tile_id exp %0d got %0d", $time, want.tile_id, got.tile_id);
          if (got.is_new != want.is_new)
            $display("%0t: is_new exp %0d got %0d", $time, want.is_new, got.is_new);
          if (got.occurrences != want.occurrences)
            $display("%0t: occurrences exp %0d got %0d", $time, want.occurrences,
                     got.occurrences);
          if (got.unique_total != want.unique_total)
            $display("%0t: unique_total exp %0d got %0d", $time, want.unique_total,
                     got.unique_total);
          if (got.table_full != want.table_full)
            $display("%0t: table_full exp %0d got %0d", $time, want.table_full,
                     got.table_full);
          if (got != want) errors++;
        end
      end
    end
  end

  initial begin
    int unsigned sizes[8];
    sizes = '{0, 16, 31, 2, 3, 4, 1, 9};
    errors = 0;
    uniq_cnt = 0;
    pix_pos = 0;
    tile_size_reg = tdi_pkg::PPT_RESET;
    burst_left = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_kind <= tdi_pkg::KIND_PIXEL;
    in_red <= 8'h00;
    in_green <= 8'h00;
    in_blue <= 8'h00;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= tdi_pkg::REG_PPT;
    pwdata <= 32'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset tile size first, then directed rows with one-pixel tiles
    run_tiles(150);
    write_tile_size(32'd1);
    foreach (dir_tab[i])
      send_item(dir_tab[i].kind, {dir_tab[i].red, dir_tab[i].green, dir_tab[i].blue},
                dir_tab[i].typed, dir_tab[i].res);

    // fill the table and overflow it
    write_tile_size(32'd1);
    for (int i = 0; i < 262; i++)
      send_item(tdi_pkg::KIND_PIXEL, {8'(i), 8'(~i), 8'(i >> 8)}, 1'b0, '0);
    send_item(tdi_pkg::KIND_PIXEL, {8'd5, 8'hfa, 8'd0}, 1'b0, '0);

    // one tile repeated
    send_item(tdi_pkg::KIND_CLEAR, 24'h000000, 1'b0, '0);
    for (int i = 0; i < 20; i++)
      send_item(tdi_pkg::KIND_PIXEL, 24'h123456, 1'b0, '0);

    foreach (sizes[i]) begin
      write_tile_size(sizes[i]);
      run_tiles(175);
    end

    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
